// ===== rtl/lzbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ bitstream decompressor package
// Shared constants, result kinds and the result request type used between
// the decoder core and the output stage.
// ----------------------------------------------------------------------------
package lzbd_pkg;

  localparam int BYTES_W = 24;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_HDR  = 2'd2;
  localparam logic [1:0] KIND_REF  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic       eoi;
    logic [1:0] kind;
    logic [7:0] data;
  } lzbd_req_t;

endpackage

// ===== rtl/lzbd_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// History window
// Single write port, single registered read port byte memory holding the
// most recent decompressed bytes.
// ----------------------------------------------------------------------------
module lzbd_window #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lzbd_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output stage
// Holds one result back so that the last result of each item can be marked,
// and drives the registered output channel.
// ----------------------------------------------------------------------------
module lzbd_emit (
  input  logic              clk,
  input  logic              rst,
  input  lzbd_pkg::lzbd_req_t req,
  output logic              req_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [7:0]        out_byte,
  output logic              last
);

  import lzbd_pkg::*;

  logic       hold_valid;
  logic [1:0] hold_kind;
  logic [7:0] hold_data;
  logic       out_free;
  logic       req_acc;

  assign out_free  = !out_valid || out_ready;
  assign req_ready = !hold_valid || out_free;
  assign req_acc   = req.valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req_acc && hold_valid) begin
        out_valid <= 1'b1;
        kind      <= hold_kind;
        out_byte  <= hold_data;
        last      <= req.eoi;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (req_acc) begin
        if (req.eoi) begin
          hold_valid <= 1'b0;
        end else begin
          hold_valid <= 1'b1;
          hold_kind  <= req.kind;
          hold_data  <= req.data;
        end
      end
    end
  end

endmodule

// ===== rtl/lzbd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder core
// Sequencer that parses the header and token bits one per cycle when not busy,
// checks matches and replays them byte by byte through the history window.
// ----------------------------------------------------------------------------
module lzbd_core #(
  parameter int WINDOW_SIZE      = 16384,
  parameter int MAX_LENGTH_WIDTH = 4,
  parameter int MAX_OFFSET_WIDTH = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  input  logic [lzbd_pkg::BYTES_W-1:0] output_length,
  output lzbd_pkg::lzbd_req_t          req,
  input  logic                         req_ready
);

  import lzbd_pkg::*;

  localparam int AW  = $clog2(WINDOW_SIZE);
  localparam int LWW = $clog2(MAX_LENGTH_WIDTH + 1);
  localparam int OWW = $clog2(MAX_OFFSET_WIDTH + 1);
  localparam int FVW = (MAX_OFFSET_WIDTH > 8) ? MAX_OFFSET_WIDTH : 8;
  localparam int BLW = $clog2(FVW + 1);
  localparam int SW  = MAX_OFFSET_WIDTH + 2;
  localparam int CNW = MAX_LENGTH_WIDTH + 1;
  localparam int CW  = (SW > AW + 1) ? SW : AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BIT   = 4'd1;
  localparam logic [3:0] S_FIELD = 4'd2;
  localparam logic [3:0] S_MCHK  = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CPY   = 4'd6;
  localparam logic [3:0] S_LIT   = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_STOP  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [2:0] PH_PREFIX1 = 3'd0;
  localparam logic [2:0] PH_PREFIX2 = 3'd1;
  localparam logic [2:0] PH_NEAR    = 3'd2;
  localparam logic [2:0] PH_FAR     = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_LITERAL = 3'd5;

  localparam logic [1:0] HS_LENGTH = 2'd0;
  localparam logic [1:0] HS_NEAR   = 2'd1;
  localparam logic [1:0] HS_FAR    = 2'd2;
  localparam logic [1:0] HS_TOKENS = 2'd3;

  logic [3:0]         state;
  logic [1:0]         hstep;
  logic [LWW-1:0]     lw;
  logic [OWW-1:0]     nw;
  logic [OWW-1:0]     fw;
  logic [2:0]         phase;
  logic [FVW-1:0]     fv;
  logic [BLW-1:0]     bleft;
  logic [SW-1:0]      span;
  logic [BYTES_W-1:0] bo;
  logic               finished;
  logic [7:0]         shreg;
  logic [3:0]         bcnt;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      rp;
  logic [CNW-1:0]     cnt;
  logic [1:0]         ekind;

  logic                        in_acc;
  logic                        req_acc;
  logic                        bit_in;
  logic [3:0]                  bcnt_dec;
  logic [3:0]                  after_bit;
  logic [3:0]                  after_field;
  logic [BLW-1:0]              bleft_dec;
  logic [FVW-1:0]              fv_shift;
  logic [BYTES_W-1:0]          remaining;
  logic [MAX_LENGTH_WIDTH-1:0] n_len;
  logic                        term;
  logic                        refbad;
  logic [CW-1:0]               span_c;
  logic [CW-1:0]               win_c;
  logic [CW-1:0]               wp_c;
  logic [CW-1:0]               mod_sub;
  logic [CW-1:0]               rp_start;
  logic [AW-1:0]               wp_inc;
  logic [AW-1:0]               rp_inc;
  logic [7:0]                  rdata;

  assign in_ready    = (state == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign req_acc     = req.valid && req_ready;
  assign bit_in      = shreg[7];
  assign bcnt_dec    = bcnt - 4'd1;
  assign after_bit   = (bcnt_dec != 4'd0) ? S_BIT : S_DONE;
  assign after_field = (bcnt != 4'd0) ? S_BIT : S_DONE;
  assign bleft_dec   = (bleft != '0) ? bleft - BLW'(1) : bleft;
  assign fv_shift    = {fv[FVW-2:0], bit_in};
  assign remaining   = (output_length > bo) ? output_length - bo : '0;
  assign n_len       = fv[MAX_LENGTH_WIDTH-1:0];
  assign term        = (25'(n_len) + 25'd1) >= {1'b0, remaining};
  assign refbad      = BYTES_W'(span) > bo;
  assign span_c      = CW'(span);
  assign win_c       = CW'(WINDOW_SIZE);
  assign wp_c        = CW'(wp);
  assign mod_sub     = span_c - win_c;
  assign rp_start    = (wp_c >= span_c) ? wp_c - span_c : wp_c + win_c - span_c;
  assign wp_inc      = (wp == AW'(WINDOW_SIZE - 1)) ? '0 : wp + AW'(1);
  assign rp_inc      = (rp == AW'(WINDOW_SIZE - 1)) ? '0 : rp + AW'(1);

  always_comb begin
    req.valid = (state == S_LIT) || (state == S_CPY) || (state == S_STOP) ||
                (state == S_DONE);
    req.eoi   = (state == S_DONE);
    req.kind  = (state == S_STOP) ? ekind : KIND_DATA;
    case (state)
      S_LIT:   req.data = fv[7:0];
      S_CPY:   req.data = rdata;
      default: req.data = 8'd0;
    endcase
  end

  lzbd_window #(
    .DEPTH (WINDOW_SIZE),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .we    (req_acc && ((state == S_LIT) || (state == S_CPY))),
    .waddr (wp),
    .wdata (req.data),
    .re    (state == S_RD),
    .raddr (rp),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      hstep    <= HS_LENGTH;
      lw       <= '0;
      nw       <= '0;
      fw       <= '0;
      phase    <= PH_PREFIX1;
      fv       <= '0;
      bleft    <= '0;
      span     <= '0;
      bo       <= '0;
      finished <= 1'b0;
      shreg    <= '0;
      bcnt     <= '0;
      wp       <= '0;
      rp       <= '0;
      cnt      <= '0;
      ekind    <= KIND_END;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && !finished) begin
            case (hstep)
              HS_LENGTH: begin
                hstep <= HS_NEAR;
                if (in_byte > 8'(MAX_LENGTH_WIDTH)) begin
                  ekind <= KIND_HDR;
                  state <= S_STOP;
                end else begin
                  lw    <= in_byte[LWW-1:0];
                  state <= S_DONE;
                end
              end
              HS_NEAR: begin
                hstep <= HS_FAR;
                if (in_byte > 8'(MAX_OFFSET_WIDTH)) begin
                  ekind <= KIND_HDR;
                  state <= S_STOP;
                end else begin
                  nw    <= in_byte[OWW-1:0];
                  state <= S_DONE;
                end
              end
              HS_FAR: begin
                hstep <= HS_TOKENS;
                if (in_byte > 8'(MAX_OFFSET_WIDTH)) begin
                  ekind <= KIND_HDR;
                  state <= S_STOP;
                end else begin
                  fw <= in_byte[OWW-1:0];
                  if (bo >= output_length) begin
                    ekind <= KIND_END;
                    state <= S_STOP;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
              default: begin
                shreg <= in_byte;
                bcnt  <= 4'd8;
                state <= S_BIT;
              end
            endcase
          end
        end
        S_BIT: begin
          shreg <= {shreg[6:0], 1'b0};
          bcnt  <= bcnt_dec;
          case (phase)
            PH_PREFIX1: begin
              if (!bit_in) begin
                phase <= PH_NEAR;
                fv    <= '0;
                bleft <= BLW'(nw);
                state <= (nw == '0) ? S_FIELD : after_bit;
              end else begin
                phase <= PH_PREFIX2;
                state <= after_bit;
              end
            end
            PH_PREFIX2: begin
              fv <= '0;
              if (!bit_in) begin
                phase <= PH_FAR;
                bleft <= BLW'(fw);
                state <= (fw == '0) ? S_FIELD : after_bit;
              end else begin
                phase <= PH_LITERAL;
                bleft <= BLW'(8);
                state <= after_bit;
              end
            end
            default: begin
              fv    <= fv_shift;
              bleft <= bleft_dec;
              state <= (bleft_dec == '0) ? S_FIELD : after_bit;
            end
          endcase
        end
        S_FIELD: begin
          case (phase)
            PH_NEAR, PH_FAR: begin
              if (phase == PH_NEAR) begin
                span <= SW'(fv) + SW'(2);
              end else begin
                span <= SW'(fv) + (SW'(1) << nw) + SW'(2);
              end
              phase <= PH_LENGTH;
              fv    <= '0;
              bleft <= BLW'(lw);
              state <= (lw == '0) ? S_FIELD : after_field;
            end
            PH_LENGTH: begin
              phase <= PH_PREFIX1;
              state <= S_MCHK;
            end
            default: begin
              phase <= PH_PREFIX1;
              state <= S_LIT;
            end
          endcase
        end
        S_MCHK: begin
          if (term) begin
            ekind <= KIND_END;
            state <= S_STOP;
          end else if (refbad) begin
            ekind <= KIND_REF;
            state <= S_STOP;
          end else begin
            cnt   <= CNW'(n_len) + CNW'(2);
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (span_c >= win_c) begin
            span <= SW'(mod_sub);
          end else begin
            rp    <= AW'(rp_start);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CPY;
        end
        S_CPY: begin
          if (req_acc) begin
            bo  <= bo + BYTES_W'(1);
            wp  <= (bo == '1) ? '0 : wp_inc;
            rp  <= rp_inc;
            cnt <= cnt - CNW'(1);
            state <= (cnt == CNW'(1)) ? S_CHK : S_RD;
          end
        end
        S_LIT: begin
          if (req_acc) begin
            bo    <= bo + BYTES_W'(1);
            wp    <= (bo == '1) ? '0 : wp_inc;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (bo >= output_length) begin
            ekind <= KIND_END;
            state <= S_STOP;
          end else begin
            state <= after_field;
          end
        end
        S_STOP: begin
          if (req_acc) begin
            finished <= 1'b1;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (req_acc) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lz_bitstream_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ bitstream decompressor
// Decodes an LZSS-style token stream one compressed byte per item, with a
// three-byte header, literals and near or far matches copied through a
// history window, and one result item per decompressed byte or status.
// ----------------------------------------------------------------------------
// Each input item is worked on alone and in_ready stays low until all of its
// results have been handed to the output stage. A header item is accepted
// and then closed, with a status step between when it ends the stream. A
// token item is accepted, then works through each token bit (eight in all),
// each completed field, each literal as an output step and a count check,
// and each match as a check, an address step that first subtracts the window
// size while the distance is at least that size, a read and a write step per
// copied byte, since every copy reads the single read port of the window
// memory and then writes it back, and a count check. Ending the stream adds
// a status step, a final step closes the item, and output back-pressure can
// stall output steps. The window memory is not cleared after reset.
module lz_bitstream_decompressor #(
  parameter int WINDOW_SIZE      = 16384,
  parameter int MAX_LENGTH_WIDTH = 4,
  parameter int MAX_OFFSET_WIDTH = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lzbd_pkg::PADDR_W-1:0] paddr,
  input  logic [lzbd_pkg::PDATA_W-1:0] pwdata,
  output logic [lzbd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [7:0]                   out_byte,
  output logic                         last
);

  import lzbd_pkg::*;

  logic [BYTES_W-1:0] output_length;
  lzbd_req_t          req;
  logic               req_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUTPUT_LENGTH) ?
                  PDATA_W'(output_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_OUTPUT_LENGTH)) begin
      output_length <= pwdata[BYTES_W-1:0];
    end
  end

  lzbd_core #(
    .WINDOW_SIZE      (WINDOW_SIZE),
    .MAX_LENGTH_WIDTH (MAX_LENGTH_WIDTH),
    .MAX_OFFSET_WIDTH (MAX_OFFSET_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .output_length (output_length),
    .req           (req),
    .req_ready     (req_ready)
  );

  lzbd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// ===== rtl/lzbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ bitstream decompressor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lzbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic       last
);

  import lzbd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(kind) && $stable(out_byte) && $stable(last))
    else $error("Result item changed while stalled.");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DATA) |-> out_byte == 8'd0)
    else $error("Status item carries a non-zero byte.");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_DATA) |-> last)
    else $error("Status item is not the last of its input item.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result item present straight after reset.");

endmodule

bind lz_bitstream_decompressor lzbd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_byte  (out_byte),
  .last      (last)
);
